// ----- hdl/multiturn_encoder_tracker_macros.svh -----
// Assertion macros for the multi-turn encoder tracker.
// Included by the top level; no other dependencies.
`ifndef MULTITURN_ENCODER_TRACKER_MACROS_SVH
`define MULTITURN_ENCODER_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MET_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker assertion failed (next cycle)");

`endif

// ----- hdl/met_pkg.sv -----
// Shared types and constants for the multi-turn encoder tracker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

   localparam int ANGLE_BITS_DEF    = 14;
   localparam int TURN_BITS         = 18;
   localparam int POS_BITS          = 32;
   localparam int SEQ_BITS          = 32;
   localparam int TIME_BITS         = 32;
   localparam int MODE_BITS         = 2;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 32;
   localparam int RSP_DATA_BITS     = 152;

   localparam logic [TIME_BITS-1:0] SAVE_INTERVAL_RST = 32'd1000;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SAMPLE     = 2'd0,
      MODE_RESTORE    = 2'd1,
      MODE_SAVE_CHECK = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ZERO_OFFSET    = 2'd0,
      CSR_SAVE_ENABLED   = 2'd1,
      CSR_SAVE_ON_CHANGE = 2'd2,
      CSR_SAVE_INTERVAL  = 2'd3
   } csr_index_type;

   // Checkpoint decision handed from the save checker to the top level.
   typedef struct packed {
      logic take;   // write a checkpoint for this word
      logic due;    // save interval has elapsed
   } save_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/met_nearest_turn.sv -----
// Nearest-turn estimate from a saved raw position and a current angle.
// Depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_nearest_turn #(
   parameter int ANGLE_BITS = met_pkg::ANGLE_BITS_DEF
) (
   input  wire logic [met_pkg::POS_BITS-1:0]  saved,
   input  wire logic [ANGLE_BITS-1:0]         angle,
   output      logic [met_pkg::TURN_BITS-1:0] turn
);

   localparam int HALF_TURN = 1 << (ANGLE_BITS - 1);
   localparam logic signed [ANGLE_BITS:0] HALF_POS = (ANGLE_BITS + 1)'(HALF_TURN);
   localparam logic signed [ANGLE_BITS:0] HALF_NEG = (ANGLE_BITS + 1)'(-HALF_TURN);

   logic signed [met_pkg::POS_BITS-1:0] shifted;
   logic signed [ANGLE_BITS:0]          delta;
   logic [met_pkg::TURN_BITS-1:0]       base;

   always_comb begin
      shifted = $signed(saved) >>> ANGLE_BITS;
      base    = shifted[met_pkg::TURN_BITS-1:0];
      delta   = $signed({1'b0, angle}) - $signed({1'b0, saved[ANGLE_BITS-1:0]});
      // Step back a turn when the angle sits more than half a turn above
      // the saved angle, forward when more than half a turn below.
      if (delta > HALF_POS) begin
         turn = base - met_pkg::TURN_BITS'(1);
      end else if (delta < HALF_NEG) begin
         turn = base + met_pkg::TURN_BITS'(1);
      end else begin
         turn = base;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/met_step.sv -----
// Turn tracking and raw position rebuild for sample and restore words.
// Depends on met_pkg and met_nearest_turn.
`timescale 1ns / 1ps
`default_nettype none

module met_step #(
   parameter int ANGLE_BITS = met_pkg::ANGLE_BITS_DEF
) (
   input  wire logic [met_pkg::MODE_BITS-1:0] mode,
   input  wire logic [ANGLE_BITS-1:0]         angle,
   input  wire logic [met_pkg::POS_BITS-1:0]  saved_position,
   input  wire logic [met_pkg::TURN_BITS-1:0] turns,
   input  wire logic [ANGLE_BITS-1:0]         prior_angle,
   input  wire logic [met_pkg::POS_BITS-1:0]  raw_pos,
   output      logic [met_pkg::TURN_BITS-1:0] turns_next,
   output      logic [met_pkg::POS_BITS-1:0]  raw_next,
   output      logic                          angle_load
);

   localparam int QUARTER = 1 << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(QUARTER);
   localparam logic [ANGLE_BITS-1:0] THREE_QUARTERS = ANGLE_BITS'(3 * QUARTER);

   logic [met_pkg::TURN_BITS-1:0] restore_turn;
   logic [met_pkg::TURN_BITS-1:0] turn_sel;
   logic [met_pkg::POS_BITS-1:0]  turn_ext;

   met_nearest_turn #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_restore_turn (
      .saved (saved_position),
      .angle (angle),
      .turn  (restore_turn)
   );

   always_comb begin
      turn_sel   = turns;
      angle_load = 1'b0;
      case (mode)
         met_pkg::MODE_SAMPLE: begin
            angle_load = 1'b1;
            if (prior_angle > THREE_QUARTERS && angle < QUARTER_TURN) begin
               turn_sel = turns + met_pkg::TURN_BITS'(1);
            end else if (prior_angle < QUARTER_TURN && angle > THREE_QUARTERS) begin
               turn_sel = turns - met_pkg::TURN_BITS'(1);
            end
         end
         met_pkg::MODE_RESTORE: begin
            angle_load = 1'b1;
            turn_sel   = restore_turn;
         end
         default: begin
            turn_sel   = turns;
            angle_load = 1'b0;
         end
      endcase
      turns_next = turn_sel;
      turn_ext   = {{(met_pkg::POS_BITS - met_pkg::TURN_BITS){turn_sel[met_pkg::TURN_BITS-1]}},
                    turn_sel};
      if (angle_load) begin
         raw_next = (turn_ext << ANGLE_BITS) + met_pkg::POS_BITS'(angle);
      end else begin
         raw_next = raw_pos;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/met_save_check.sv -----
// Checkpoint decision for save-check words.
// Depends on met_pkg and met_nearest_turn.
`timescale 1ns / 1ps
`default_nettype none

module met_save_check #(
   parameter int ANGLE_BITS = met_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                          check,
   input  wire logic                          save_enabled,
   input  wire logic                          save_on_change,
   input  wire logic [met_pkg::TIME_BITS-1:0] save_interval,
   input  wire logic [met_pkg::POS_BITS-1:0]  checkpoint_position,
   input  wire logic [ANGLE_BITS-1:0]         prior_angle,
   input  wire logic [met_pkg::TURN_BITS-1:0] turns,
   input  wire logic [met_pkg::TIME_BITS-1:0] current_time,
   input  wire logic [met_pkg::TIME_BITS-1:0] last_save_time,
   output      met_pkg::save_ctl_type         ctl
);

   logic [met_pkg::TURN_BITS-1:0] implied_turn;
   logic [met_pkg::TIME_BITS-1:0] elapsed;
   logic                          changed;

   met_nearest_turn #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_implied_turn (
      .saved (checkpoint_position),
      .angle (prior_angle),
      .turn  (implied_turn)
   );

   always_comb begin
      elapsed  = current_time - last_save_time;
      changed  = implied_turn != turns;
      ctl.due  = elapsed > save_interval;
      ctl.take = check && save_enabled && changed && (save_on_change || ctl.due);
   end

endmodule

`default_nettype wire

// ----- hdl/multiturn_encoder_tracker.sv -----
// Top level of the multi-turn encoder tracker: stream ports, state, registers.
// Depends on met_pkg, met_step, met_save_check and the macros header.
//
//   channel   dir  handshake              payload
//   req_      in   req_tvalid/req_tready  tuser: mode; tdata: angle, checkpoint, time
//   rsp_      out  rsp_tvalid/rsp_tready  tdata: positions, turns, checkpoint
//   csr_      in   csr_wen                csr_index, csr_wdata
//
// One word per cycle sustained while rsp_tready is high; each word sits in the input
// register and then lands in the result register.
// The turn and checkpoint state updates in the same cycle a word moves into the
// result register, so the next word always sees the state the previous one left.
// Reset (synchronous, active high) empties both registers and restores state.
// A stalled rsp_tready holds the result; the input register still takes one word.
`timescale 1ns / 1ps
`default_nettype none

`include "multiturn_encoder_tracker_macros.svh"

module multiturn_encoder_tracker #(
   parameter int ANGLE_BITS = met_pkg::ANGLE_BITS_DEF,
   localparam int REQ_DATA_W = ((ANGLE_BITS + 3 * 32 + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // tuser: mode[1:0]
   input  wire logic [met_pkg::MODE_BITS-1:0]      req_tuser,
   // tdata: single_turn[ANGLE_BITS], saved_position[32], saved_sequence[32],
   //        current_time[32], zero pad
   input  wire logic [REQ_DATA_W-1:0]              req_tdata,
   // result stream
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: position[31:0], raw_position[63:32], turn_count[81:64],
   //        save_now[82], save_position[114:83], save_sequence[146:115], pad
   output      logic [met_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // register write port
   input  wire logic                               csr_wen,
   input  wire logic [met_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [met_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int P = met_pkg::POS_BITS;
   localparam int SP_LO = ANGLE_BITS;
   localparam int SS_LO = SP_LO + P;
   localparam int CT_LO = SS_LO + met_pkg::SEQ_BITS;

   // configuration registers
   logic [P-1:0]                  zero_offset_ff;
   logic                          save_en_ff;
   logic                          save_chg_ff;
   logic [met_pkg::TIME_BITS-1:0] save_int_ff;

   // tracker state
   logic [met_pkg::TURN_BITS-1:0] turns_ff, turns_in;
   logic [ANGLE_BITS-1:0]         prior_ff, prior_in;
   logic [P-1:0]                  raw_ff, raw_in;
   logic [P-1:0]                  cp_pos_ff, cp_pos_in;
   logic [met_pkg::SEQ_BITS-1:0]  cp_seq_ff, cp_seq_in;
   logic [met_pkg::TIME_BITS-1:0] last_time_ff, last_time_in;

   // input register
   logic                          in_vld_ff;
   logic [met_pkg::MODE_BITS-1:0] in_mode_ff;
   logic [ANGLE_BITS-1:0]         in_angle_ff;
   logic [P-1:0]                  in_spos_ff;
   logic [met_pkg::SEQ_BITS-1:0]  in_sseq_ff;
   logic [met_pkg::TIME_BITS-1:0] in_time_ff;

   // result register
   logic                              rsp_vld_ff;
   logic [met_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                          advance;
   logic                          fire;
   logic                          angle_load;
   logic [met_pkg::TURN_BITS-1:0] step_turns;
   logic [P-1:0]                  step_raw;
   met_pkg::save_ctl_type         save;

   // The result register frees up when empty or being taken this cycle.
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= '0;
         save_en_ff     <= 1'b0;
         save_chg_ff    <= 1'b0;
         save_int_ff    <= met_pkg::SAVE_INTERVAL_RST;
      end else if (csr_wen) begin
         case (csr_index)
            met_pkg::CSR_ZERO_OFFSET:    zero_offset_ff <= csr_wdata[P-1:0];
            met_pkg::CSR_SAVE_ENABLED:   save_en_ff     <= csr_wdata[0];
            met_pkg::CSR_SAVE_ON_CHANGE: save_chg_ff    <= csr_wdata[0];
            met_pkg::CSR_SAVE_INTERVAL:  save_int_ff    <= csr_wdata[met_pkg::TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input register: hold a word until the result side can take it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff  <= req_tuser;
         in_angle_ff <= req_tdata[ANGLE_BITS-1:0];
         in_spos_ff  <= req_tdata[SP_LO +: P];
         in_sseq_ff  <= req_tdata[SS_LO +: met_pkg::SEQ_BITS];
         in_time_ff  <= req_tdata[CT_LO +: met_pkg::TIME_BITS];
      end
   end

   met_step #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_step (
      .mode           (in_mode_ff),
      .angle          (in_angle_ff),
      .saved_position (in_spos_ff),
      .turns          (turns_ff),
      .prior_angle    (prior_ff),
      .raw_pos        (raw_ff),
      .turns_next     (step_turns),
      .raw_next       (step_raw),
      .angle_load     (angle_load)
   );

   met_save_check #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_save_check (
      .check               (in_mode_ff == met_pkg::MODE_SAVE_CHECK),
      .save_enabled        (save_en_ff),
      .save_on_change      (save_chg_ff),
      .save_interval       (save_int_ff),
      .checkpoint_position (cp_pos_ff),
      .prior_angle         (prior_ff),
      .turns               (turns_ff),
      .current_time        (in_time_ff),
      .last_save_time      (last_time_ff),
      .ctl                 (save)
   );

   // next state and result for the word in the input register
   always_comb begin
      turns_in     = step_turns;
      raw_in       = step_raw;
      prior_in     = angle_load ? in_angle_ff : prior_ff;
      cp_pos_in    = cp_pos_ff;
      cp_seq_in    = cp_seq_ff;
      last_time_in = last_time_ff;
      if (in_mode_ff == met_pkg::MODE_RESTORE) begin
         // adopt the stored checkpoint as is
         cp_pos_in = in_spos_ff;
         cp_seq_in = in_sseq_ff;
      end else if (save.take) begin
         // take a checkpoint of the current raw position
         cp_pos_in    = raw_ff;
         cp_seq_in    = cp_seq_ff + met_pkg::SEQ_BITS'(1);
         last_time_in = in_time_ff;
      end
      rsp_data_in = {5'd0, cp_seq_in, cp_pos_in, save.take, turns_in, raw_in,
                     raw_in - zero_offset_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turns_ff     <= '0;
         prior_ff     <= '0;
         raw_ff       <= '0;
         cp_pos_ff    <= '0;
         cp_seq_ff    <= '0;
         last_time_ff <= '0;
      end else if (fire) begin
         turns_ff     <= turns_in;
         prior_ff     <= prior_in;
         raw_ff       <= raw_in;
         cp_pos_ff    <= cp_pos_in;
         cp_seq_ff    <= cp_seq_in;
         last_time_ff <= last_time_in;
      end
   end

   // result register: load on fire, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   `MET_ASSERT_NEXT(a_seq_advances, clock, reset, fire && save.take,
                    cp_seq_ff == $past(cp_seq_ff) + met_pkg::SEQ_BITS'(1))
   `MET_ASSERT_NOW(a_save_waits_interval, clock, reset, save.take && !save_chg_ff,
                   save.due)
   `MET_ASSERT_NOW(a_full_stall_blocks, clock, reset, in_vld_ff && rsp_vld_ff && !rsp_tready,
                   !req_tready)
   `MET_ASSERT_NEXT(a_sample_single_step, clock, reset,
                    fire && in_mode_ff == met_pkg::MODE_SAMPLE,
                    turns_ff == $past(turns_ff)
                    || turns_ff == $past(turns_ff) + met_pkg::TURN_BITS'(1)
                    || turns_ff == $past(turns_ff) - met_pkg::TURN_BITS'(1))

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the multi-turn encoder tracker: directed and random words.
// Needs met_pkg and the multiturn_encoder_tracker RTL; a class predicts each result.

module testbench;
   import met_pkg::*;

   localparam int ANGLE_W        = ANGLE_BITS_DEF;
   localparam int ANGLE_MAX      = (1 << ANGLE_W) - 1;
   localparam int HALF_TURN      = 1 << (ANGLE_W - 1);
   localparam int QUARTER_TURN   = HALF_TURN / 2;
   localparam int THREE_QUARTERS = QUARTER_TURN * 3;
   localparam int REQ_BITS       = ((ANGLE_W + 3 * 32 + 7) / 8) * 8;
   // Mode code the block must treat as a no-op that still reports.
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   // Roughly 715 words; even with both sides stalling often, this bound is many
   // times the slowest clean run.
   localparam int CYCLE_LIMIT = 300000;

   // Request payload, first field in the low bits.
   typedef struct packed {
      logic [TIME_BITS-1:0]  current_time;
      logic [SEQ_BITS-1:0]   saved_sequence;
      logic [POS_BITS-1:0]   saved_position;
      logic [ANGLE_W-1:0]    single_turn;
   } request_t;

   // Result payload, first field in the low bits.
   typedef struct packed {
      logic [SEQ_BITS-1:0]   save_sequence;
      logic [POS_BITS-1:0]   save_position;
      logic                  save_now;
      logic [TURN_BITS-1:0]  turn_count;
      logic [POS_BITS-1:0]   raw_position;
      logic [POS_BITS-1:0]   position;
   } report_t;

   // Tracks turns and checkpoint state, queues the report each word must produce.
   class position_tracker;
      logic [POS_BITS-1:0]  zero_offset;
      logic                 save_enabled;
      logic                 save_on_change;
      logic [TIME_BITS-1:0] save_interval;
      logic [TURN_BITS-1:0] turns;
      logic [ANGLE_W-1:0]   prior_angle;
      logic [POS_BITS-1:0]  raw_pos;
      logic [POS_BITS-1:0]  ckpt_position;
      logic [SEQ_BITS-1:0]  ckpt_sequence;
      logic [TIME_BITS-1:0] last_save_time;
      report_t              expected_reports[$];
      int                   mismatches;

      function new();
         zero_offset    = '0;
         save_enabled   = 1'b0;
         save_on_change = 1'b0;
         save_interval  = SAVE_INTERVAL_RST;
         turns          = '0;
         prior_angle    = '0;
         raw_pos        = '0;
         ckpt_position  = '0;
         ckpt_sequence  = '0;
         last_save_time = '0;
         mismatches     = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_ZERO_OFFSET:    zero_offset    = value;
            CSR_SAVE_ENABLED:   save_enabled   = value[0];
            CSR_SAVE_ON_CHANGE: save_on_change = value[0];
            CSR_SAVE_INTERVAL:  save_interval  = value;
            default: ;
         endcase
      endfunction

      // Nearest whole turn to a saved position given the angle seen now.
      function logic [TURN_BITS-1:0] implied_turn(logic [POS_BITS-1:0] saved,
                                                  logic [ANGLE_W-1:0] angle);
         logic signed [POS_BITS-1:0] t;
         int delta;
         t = $signed(saved) >>> ANGLE_W;
         delta = int'(angle) - int'(saved[ANGLE_W-1:0]);
         if (delta > HALF_TURN)
            t = t - 1;
         else if (-delta > HALF_TURN)
            t = t + 1;
         return t[TURN_BITS-1:0];
      endfunction

      function void predict_report(logic [MODE_BITS-1:0] mode, request_t word);
         report_t              rep;
         logic                 taken;
         logic                 changed;
         logic [TIME_BITS-1:0] elapsed;
         taken = 1'b0;
         case (mode)
            MODE_SAMPLE: begin
               if (prior_angle > THREE_QUARTERS && word.single_turn < QUARTER_TURN)
                  turns = turns + 1'b1;
               else if (prior_angle < QUARTER_TURN && word.single_turn > THREE_QUARTERS)
                  turns = turns - 1'b1;
               // turns * 2^14 + angle, wrapped to 32 bits, is just the concatenation
               raw_pos     = {turns, word.single_turn};
               prior_angle = word.single_turn;
            end
            MODE_RESTORE: begin
               turns         = implied_turn(word.saved_position, word.single_turn);
               raw_pos       = {turns, word.single_turn};
               prior_angle   = word.single_turn;
               ckpt_position = word.saved_position;
               ckpt_sequence = word.saved_sequence;
            end
            MODE_SAVE_CHECK: begin
               if (save_enabled) begin
                  changed = implied_turn(ckpt_position, prior_angle) != turns;
                  elapsed = word.current_time - last_save_time;
                  if (changed && (save_on_change || elapsed > save_interval)) begin
                     ckpt_position  = raw_pos;
                     ckpt_sequence  = ckpt_sequence + 1'b1;
                     last_save_time = word.current_time;
                     taken          = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         rep.position      = raw_pos - zero_offset;
         rep.raw_position  = raw_pos;
         rep.turn_count    = turns;
         rep.save_now      = taken;
         rep.save_position = ckpt_position;
         rep.save_sequence = ckpt_sequence;
         expected_reports.push_back(rep);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void compare_report(report_t got);
         report_t want;
         if (expected_reports.size() == 0) begin
            $error("result word with nothing pending: %0h", got);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         check_field("position", want.position, got.position);
         check_field("raw_position", want.raw_position, got.raw_position);
         check_field("turn_count", want.turn_count, got.turn_count);
         check_field("save_now", want.save_now, got.save_now);
         check_field("save_position", want.save_position, got.save_position);
         check_field("save_sequence", want.save_sequence, got.save_sequence);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [MODE_BITS-1:0]       req_tuser;
   logic [REQ_BITS-1:0]        req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                       csr_wen;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   position_tracker tracker = new();

   // Stall odds in percent for each side; changed between phases.
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;

   // Stimulus-side memory: the angle last sampled and the uptime counter.
   logic [ANGLE_W-1:0]   stim_angle;
   logic [TIME_BITS-1:0] stim_time;

   multiturn_encoder_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Throttle the result side at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Check every result word taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.compare_report(rsp_tdata[$bits(report_t)-1:0]);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic request_t make_word(int angle, logic [31:0] pos,
                                          logic [31:0] seq, logic [31:0] t);
      request_t w;
      w.single_turn    = angle[ANGLE_W-1:0];
      w.saved_position = pos;
      w.saved_sequence = seq;
      w.current_time   = t;
      return w;
   endfunction

   // Offer one word, idling at random first; note it once the block takes it.
   task automatic send_word(logic [MODE_BITS-1:0] mode, request_t word);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_BITS - $bits(request_t)){1'b0}}, word};
      do @(posedge clock); while (!req_tready);
      tracker.predict_report(mode, word);
   endtask

   // Drop valid, wait for every pending result, then let the pipe settle.
   task automatic drain_reports();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.expected_reports.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   task automatic configure(logic [31:0] offset, logic enabled, logic on_change,
                            logic [31:0] interval);
      write_register(CSR_ZERO_OFFSET, offset);
      write_register(CSR_SAVE_ENABLED, {31'd0, enabled});
      write_register(CSR_SAVE_ON_CHANGE, {31'd0, on_change});
      write_register(CSR_SAVE_INTERVAL, interval);
   endtask

   // Mostly smooth rotation with save checks between, plus restores and noise.
   task automatic run_random(int count, bit hold_midway);
      request_t             w;
      logic [MODE_BITS-1:0] mode;
      int                   pick;
      for (int i = 0; i < count; i++) begin
         // Fill every field with junk; the mode picks which ones matter.
         w.single_turn    = ANGLE_W'($urandom_range(ANGLE_MAX, 0));
         w.saved_position = $urandom();
         w.saved_sequence = $urandom();
         w.current_time   = $urandom();
         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            // Steps up to about a fifth of a turn, crossing the wrap both ways.
            mode = MODE_SAMPLE;
            stim_angle = ANGLE_W'(int'(stim_angle) + $urandom_range(6000, 0) - 3000);
            w.single_turn = stim_angle;
         end else if (pick < 60) begin
            mode = MODE_SAMPLE;
            stim_angle = w.single_turn;
         end else if (pick < 72) begin
            mode = MODE_RESTORE;
            stim_angle = w.single_turn;
         end else if (pick < 96) begin
            // Advance uptime a little, now and then jump anywhere (wraps included).
            mode = MODE_SAVE_CHECK;
            if ($urandom_range(19, 0) == 0)
               stim_time = $urandom();
            else
               stim_time = stim_time + $urandom_range(1500, 0);
            w.current_time = stim_time;
         end else begin
            mode = MODE_UNUSED;
         end
         send_word(mode, w);
         // Hold off the sender until the block has delivered everything.
         if (hold_midway && i == count / 2)
            drain_reports();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = '0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wen       = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      cycle_count   = 0;
      send_idle_pct = 34;
      recv_idle_pct = 45;
      stim_angle    = '0;
      stim_time     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: saving off, zero offset.
      send_word(MODE_SAMPLE, make_word(0, 0, 0, 0));
      // backward wrap, then forward wrap back to turn zero
      send_word(MODE_SAMPLE, make_word(ANGLE_MAX, 0, 0, 0));
      send_word(MODE_SAMPLE, make_word(0, 0, 0, 0));
      // quarter boundaries do not count as wraps; just inside them, the last step wraps forward
      send_word(MODE_SAMPLE, make_word(QUARTER_TURN, 0, 0, 0));
      send_word(MODE_SAMPLE, make_word(THREE_QUARTERS, 0, 0, 0));
      send_word(MODE_SAMPLE, make_word(THREE_QUARTERS + 1, 0, 0, 0));
      send_word(MODE_SAMPLE, make_word(QUARTER_TURN - 1, 0, 0, 0));
      send_word(MODE_SAVE_CHECK, make_word(0, 0, 0, 32'hFFFF_FFFF));
      send_word(MODE_UNUSED, make_word(ANGLE_MAX, '1, '1, '1));
      // restore at the top of the turn range, then roll over to the bottom
      send_word(MODE_RESTORE, make_word(ANGLE_MAX, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
      send_word(MODE_SAMPLE, make_word(100, 0, 0, 0));
      send_word(MODE_RESTORE, make_word(0, 32'h8000_0000, 0, 0));
      send_word(MODE_SAMPLE, make_word(ANGLE_MAX, 0, 0, 0));
      // nearest turn: one below, one above, and exactly half a turn both ways
      send_word(MODE_RESTORE, make_word(ANGLE_MAX, 0, 1, 0));
      send_word(MODE_RESTORE, make_word(0, ANGLE_MAX, 2, 0));
      send_word(MODE_RESTORE, make_word(HALF_TURN, 0, 3, 0));
      send_word(MODE_RESTORE, make_word(0, HALF_TURN, 4, 0));
      drain_reports();

      // Saving on, zero interval: needs strictly positive elapsed time.
      configure(32'h8000_0000, 1'b1, 1'b0, 32'd0);
      send_word(MODE_SAVE_CHECK, make_word(0, 0, 0, 0));
      send_word(MODE_SAMPLE, make_word(ANGLE_MAX, 0, 0, 0));
      send_word(MODE_SAVE_CHECK, make_word(0, 0, 0, 0));
      send_word(MODE_SAVE_CHECK, make_word(0, 0, 0, 1));
      send_word(MODE_SAMPLE, make_word(0, 0, 0, 0));
      // elapsed time wraps below the last save
      send_word(MODE_SAVE_CHECK, make_word(0, 0, 0, 0));
      send_word(MODE_UNUSED, make_word(0, 0, 0, 0));
      drain_reports();
      stim_angle = '0;

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: configure($urandom(), 1'b1, 1'b0, 32'd1000);
            1: configure(32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
            2: configure(32'd0, 1'b1, 1'b0, 32'd0);
            3: configure(32'h8000_0000, 1'b0, 1'b1, $urandom());
            4: configure($urandom(), 1'b1, 1'b0, 32'hFFFF_FFFF);
            default: configure(32'hFFFF_FFFF, 1'b1, 1'b0, $urandom_range(3000, 0));
         endcase
         // Receiver stalls more often first, then the sender, then neither side stalls.
         if (p < 2) begin
            send_idle_pct = 34;
            recv_idle_pct = 45;
         end else if (p < 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_random(115, p == 1);
         drain_reports();
      end

      if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/met_pkg.sv
hdl/met_nearest_turn.sv
hdl/met_step.sv
hdl/met_save_check.sv
hdl/multiturn_encoder_tracker.sv
tb/sv/testbench.sv
